### src/dpr_pkg.sv
// shared types, codes and tables for the bitmap pixel to rgba converter
package dpr_pkg;

  localparam int PALETTE_DEPTH_DEF = 256;
  localparam int CHAN_W            = 8;
  localparam int RAW_W             = 32;
  localparam int PHASE_W           = 3;
  localparam int COUNT_W           = 9;
  localparam int FMT_W             = 3;
  localparam int CFG_IDX_W         = 2;
  localparam int CFG_DATA_W        = 9;
  localparam int ENTRY_W           = 3 * CHAN_W;

  typedef enum logic [FMT_W-1:0] {
    FMT_1BPP  = 3'd0,
    FMT_4BPP  = 3'd1,
    FMT_8BPP  = 3'd2,
    FMT_16BPP = 3'd3,
    FMT_24BPP = 3'd4,
    FMT_32BPP = 3'd5
  } fmt_t;

  typedef enum logic {
    OP_PAL_WRITE = 1'b0,
    OP_PIXEL     = 1'b1
  } op_t;

  localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_FORMAT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_COUNT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_VALID   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MASK_PRESENT  = 2'd3;

  localparam logic [FMT_W-1:0]   FMT_RESET   = FMT_32BPP;
  localparam logic [CHAN_W-1:0]  ALPHA_OPAQUE = 8'd255;
  localparam logic [CHAN_W-1:0]  ALPHA_CLEAR  = 8'd0;

  typedef struct packed {
    logic [FMT_W-1:0]   pixel_format;
    logic [COUNT_W-1:0] palette_count;
    logic               alpha_valid;
    logic               mask_present;
  } cfg_t;

  // floor(v * 255 / 31) for a 5-bit channel
  localparam logic [CHAN_W-1:0] EXPAND5_LUT [32] = '{
    8'd0,   8'd8,   8'd16,  8'd24,  8'd32,  8'd41,  8'd49,  8'd57,
    8'd65,  8'd74,  8'd82,  8'd90,  8'd98,  8'd106, 8'd115, 8'd123,
    8'd131, 8'd139, 8'd148, 8'd156, 8'd164, 8'd172, 8'd180, 8'd189,
    8'd197, 8'd205, 8'd213, 8'd222, 8'd230, 8'd238, 8'd246, 8'd255
  };

endpackage

### src/dpr_ifs.sv
// valid/ready channel interfaces for pixel input, rgba output and config writes
interface dpr_in_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [7:0]  palette_index;
  logic [7:0]  palette_blue;
  logic [7:0]  palette_green;
  logic [7:0]  palette_red;
  logic [31:0] raw_pixel;
  logic [2:0]  column_phase;
  logic [7:0]  mask_byte;

  modport source (output valid, op, palette_index, palette_blue, palette_green,
                  palette_red, raw_pixel, column_phase, mask_byte, input ready);
  modport sink   (input valid, op, palette_index, palette_blue, palette_green,
                  palette_red, raw_pixel, column_phase, mask_byte, output ready);
endinterface

interface dpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;

  modport source (output valid, red, green, blue, alpha, input ready);
  modport sink   (input valid, red, green, blue, alpha, output ready);
endinterface

interface dpr_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

### src/dpr_ram.sv
// generic single write port ram with registered read
module dpr_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### src/dpr_cfg_regs.sv
// configuration register file
module dpr_cfg_regs import dpr_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  dpr_cfg_if.sink    cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_PIXEL_FORMAT:  cfg_nxt.pixel_format  = cfg_ch.data[FMT_W-1:0];
        CFG_PALETTE_COUNT: cfg_nxt.palette_count = cfg_ch.data[COUNT_W-1:0];
        CFG_ALPHA_VALID:   cfg_nxt.alpha_valid   = cfg_ch.data[0];
        CFG_MASK_PRESENT:  cfg_nxt.mask_present  = cfg_ch.data[0];
        default:           cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format  <= FMT_RESET;
      cfg_r.palette_count <= '0;
      cfg_r.alpha_valid   <= 1'b0;
      cfg_r.mask_present  <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### src/dpr_color.sv
// rgba composition from palette data or direct source bits
module dpr_color import dpr_pkg::*; (
  input  cfg_t               cfg,
  input  logic [RAW_W-1:0]   raw,
  input  logic               pal_hit,
  input  logic [ENTRY_W-1:0] pal_entry,
  input  logic               mask_set,
  output logic [CHAN_W-1:0]  red,
  output logic [CHAN_W-1:0]  green,
  output logic [CHAN_W-1:0]  blue,
  output logic [CHAN_W-1:0]  alpha
);

  logic own_alpha;

  always_comb begin
    red       = '0;
    green     = '0;
    blue      = '0;
    alpha     = ALPHA_OPAQUE;
    own_alpha = 1'b0;
    case (cfg.pixel_format)
      FMT_1BPP, FMT_4BPP, FMT_8BPP: begin
        if (pal_hit) begin
          blue  = pal_entry[CHAN_W-1:0];
          green = pal_entry[2*CHAN_W-1:CHAN_W];
          red   = pal_entry[3*CHAN_W-1:2*CHAN_W];
        end
      end
      FMT_16BPP: begin
        red   = EXPAND5_LUT[raw[14:10]];
        green = EXPAND5_LUT[raw[9:5]];
        blue  = EXPAND5_LUT[raw[4:0]];
      end
      FMT_24BPP, FMT_32BPP: begin
        blue  = raw[7:0];
        green = raw[15:8];
        red   = raw[23:16];
        if (cfg.pixel_format == FMT_32BPP && cfg.alpha_valid) begin
          alpha     = raw[31:24];
          own_alpha = 1'b1;
        end
      end
      default: begin
        red = '0;
      end
    endcase
    if (cfg.mask_present && !own_alpha && mask_set) begin
      alpha = ALPHA_CLEAR;
    end
  end

endmodule

### src/dib_pixel_to_rgba.sv
// top level of the bitmap pixel to rgba converter
// Converts bitmap icon pixels to 8-bit RGBA at one item per clock when the output
// is not stalled. Palette-write transfers store a blue/green/red entry and return
// nothing; pixel transfers each return one RGBA result through the palette read
// register, then the output register. The palette memory has one write and one
// read port with a registered read, and a write is visible to a pixel accepted in
// the next cycle. Palette entries are undefined until written and there is no
// clearing pass after reset. Configuration writes are taken at any time but must
// only be issued while the block is idle.
module dib_pixel_to_rgba import dpr_pkg::*; #(
  parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  dpr_in_if.sink    in_ch,
  dpr_out_if.source out_ch,
  dpr_cfg_if.sink   cfg_ch
);

  localparam int IDX_W = $clog2(PALETTE_DEPTH);
  localparam logic [COUNT_W-1:0] DEPTH_LIM = COUNT_W'(PALETTE_DEPTH);

  cfg_t cfg;

  logic               in_xfer;
  logic               adv;
  logic [CHAN_W-1:0]  lo;
  logic [CHAN_W-1:0]  pix_idx;
  logic               idx_fmt;
  logic               hit;
  logic               pal_we;
  logic               pix_acc;
  logic [ENTRY_W-1:0] pal_rdata;

  logic               s1_valid_r, s1_valid_nxt;
  logic [RAW_W-1:0]   s1_raw_r;
  logic               s1_hit_r;
  logic               s1_mbit_r;

  logic               out_valid_r, out_valid_nxt;
  logic [CHAN_W-1:0]  out_red_r, out_green_r, out_blue_r, out_alpha_r;
  logic [CHAN_W-1:0]  c_red, c_green, c_blue, c_alpha;

  dpr_cfg_regs u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  assign adv         = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign pix_acc     = in_xfer && (in_ch.op == OP_PIXEL);

  assign lo = in_ch.raw_pixel[CHAN_W-1:0];

  always_comb begin
    idx_fmt = 1'b1;
    case (cfg.pixel_format)
      FMT_1BPP: pix_idx = {7'd0, lo[3'd7 - in_ch.column_phase]};
      FMT_4BPP: pix_idx = in_ch.column_phase[0] ? {4'd0, lo[3:0]} : {4'd0, lo[7:4]};
      FMT_8BPP: pix_idx = lo;
      default: begin
        pix_idx = lo;
        idx_fmt = 1'b0;
      end
    endcase
  end

  assign hit = idx_fmt && ({1'b0, pix_idx} < cfg.palette_count)
                       && ({1'b0, pix_idx} < DEPTH_LIM);

  assign pal_we = in_xfer && (in_ch.op == OP_PAL_WRITE)
                  && ({1'b0, in_ch.palette_index} < DEPTH_LIM);

  dpr_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (PALETTE_DEPTH)
  ) u_palette (
    .clk   (clk),
    .we    (pal_we),
    .waddr (in_ch.palette_index[IDX_W-1:0]),
    .wdata ({in_ch.palette_red, in_ch.palette_green, in_ch.palette_blue}),
    .re    (pix_acc),
    .raddr (pix_idx[IDX_W-1:0]),
    .rdata (pal_rdata)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_xfer) begin
      s1_valid_nxt = (in_ch.op == OP_PIXEL);
    end else if (adv) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      s1_raw_r  <= in_ch.raw_pixel;
      s1_hit_r  <= hit;
      s1_mbit_r <= in_ch.mask_byte[3'd7 - in_ch.column_phase];
    end
  end

  dpr_color u_color (
    .cfg       (cfg),
    .raw       (s1_raw_r),
    .pal_hit   (s1_hit_r),
    .pal_entry (pal_rdata),
    .mask_set  (s1_mbit_r),
    .red       (c_red),
    .green     (c_green),
    .blue      (c_blue),
    .alpha     (c_alpha)
  );

  assign out_valid_nxt = adv ? s1_valid_r : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && s1_valid_r) begin
      out_red_r   <= c_red;
      out_green_r <= c_green;
      out_blue_r  <= c_blue;
      out_alpha_r <= c_alpha;
    end
  end

  assign out_ch.valid = out_valid_r;
  assign out_ch.red   = out_red_r;
  assign out_ch.green = out_green_r;
  assign out_ch.blue  = out_blue_r;
  assign out_ch.alpha = out_alpha_r;

`ifndef ASSERT_OFF
  a_pixel_to_s1: assert property (@(posedge clk) disable iff (!rst_n)
    pix_acc |=> s1_valid_r)
    else $error("accepted pixel did not reach palette stage");

  a_write_no_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && in_ch.op == OP_PAL_WRITE) |=> !s1_valid_r)
    else $error("palette write produced a pending result");

  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !adv) |=> (s1_valid_r && $stable(pal_rdata) && $stable(s1_raw_r)))
    else $error("stalled palette stage lost its data");

  a_s1_to_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && adv) |=> out_valid_r)
    else $error("palette stage result not moved to output");

  a_no_write_during_read: assert property (@(posedge clk) disable iff (!rst_n)
    !(pal_we && pix_acc))
    else $error("palette write and read in the same cycle");
`endif

endmodule
